[rtl/ltqm_pkg.sv]
// Package for the linked task queue manager.
// Holds request/result structs, opcodes and status codes; no dependencies.
package ltqm_pkg;

  // Opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] queue_id;
    logic [5:0] task_id;
  } ltqm_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] popped_task;
    logic       now_empty;
  } ltqm_rsp_t;

endpackage

[rtl/linked_task_queue_manager.sv]
// Linked task queue manager: FIFO task queues sharing one link memory.
// Clear, out-of-range and rejected requests and append to an empty queue finish in IDLE;
// other appends pass APPEND2, pop passes POP and remove at the head passes RM_HEAD;
// remove further down walks links in WALK, then passes RM_FIX and RM_CLR; a remove that
// misses ends in WALK at the null link or at the step limit.
// Throughput: one request in flight, busy until its result; the receiver cannot stall.
// Reset clears all heads and tails; the link RAM is not cleared.
// Depends on ltqm_pkg and ltqm_ram.
module linked_task_queue_manager
  import ltqm_pkg::*;
#(
  parameter int NUM_TASKS  = 64,
  parameter int NUM_QUEUES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ltqm_req_t request,
  output logic      done,
  output ltqm_rsp_t result
);

  localparam int LW = $clog2(NUM_TASKS + 1);              // link width, includes null
  localparam int AW = $clog2(NUM_TASKS);                  // link RAM address width
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $clog2(NUM_TASKS + 1);              // walk step counter
  localparam logic [LW-1:0] NIL = LW'(NUM_TASKS);

  typedef enum logic [2:0] {
    IDLE, APPEND2, POP, RM_HEAD, WALK, RM_FIX, RM_CLR
  } state_t;

  state_t          state;
  logic [LW-1:0]   head [NUM_QUEUES];
  logic [LW-1:0]   tail [NUM_QUEUES];
  logic [QW-1:0]   qi;
  logic [LW-1:0]   tsk;
  logic [LW-1:0]   prev;
  logic [SW-1:0]   steps;

  // link RAM ports
  logic            we;
  logic [AW-1:0]   waddr;
  logic [LW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [LW-1:0]   rdata;

  // request decode
  logic [QW-1:0]   in_q;
  logic [LW-1:0]   in_t;
  logic            q_ok;
  logic            t_ok;
  logic [LW-1:0]   in_head;
  logic [LW-1:0]   cur_head;
  logic [LW-1:0]   cur_tail;

  assign busy     = (state != IDLE);
  assign in_q     = QW'(request.queue_id);
  assign in_t     = LW'(request.task_id);
  assign q_ok     = int'(request.queue_id) < NUM_QUEUES;
  assign t_ok     = int'(request.task_id) < NUM_TASKS;
  assign in_head  = head[in_q];
  assign cur_head = head[qi];
  assign cur_tail = tail[qi];

  function automatic ltqm_rsp_t mk_rsp(logic [1:0] st, logic [5:0] pt, logic em);
    ltqm_rsp_t r;
    r.status      = st;
    r.popped_task = pt;
    r.now_empty   = em;
    return r;
  endfunction

  ltqm_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Link RAM access per state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = NIL;
    raddr = '0;
    case (state)
      IDLE: begin
        // append clears the new task's link; pop/remove fetch the head's link
        if (start && q_ok && t_ok && request.opcode == OP_APPEND) begin
          we    = 1'b1;
          waddr = AW'(request.task_id);
        end
        raddr = AW'(in_head);
      end
      APPEND2: begin
        we    = (cur_tail != NIL);
        waddr = AW'(cur_tail);
        wdata = tsk;
      end
      POP: begin
        we    = 1'b1;
        waddr = AW'(cur_head);
      end
      RM_HEAD: begin
        we    = 1'b1;
        waddr = AW'(tsk);
      end
      WALK: begin
        // follow the link; if it is the target this fetches the target's link
        raddr = AW'(rdata);
      end
      RM_FIX: begin
        we    = 1'b1;
        waddr = AW'(prev);
        wdata = rdata;
      end
      RM_CLR: begin
        we    = 1'b1;
        waddr = AW'(tsk);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Sequencer, head/tail registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            qi  <= in_q;
            tsk <= in_t;
            if (!q_ok) begin
              done <= 1'b1;
              case (request.opcode)
                OP_POP:    result <= mk_rsp(ST_EMPTY, 6'd0, 1'b1);
                OP_REMOVE: result <= mk_rsp(ST_NOTFOUND, 6'd0, 1'b1);
                default:   result <= mk_rsp(ST_OK, 6'd0, 1'b1);
              endcase
            end else begin
              case (request.opcode)
                OP_CLEAR: begin
                  head[in_q] <= NIL;
                  tail[in_q] <= NIL;
                  done       <= 1'b1;
                  result     <= mk_rsp(ST_OK, 6'd0, 1'b1);
                end
                OP_APPEND: begin
                  if (!t_ok) begin
                    done   <= 1'b1;
                    result <= mk_rsp(ST_NOTFOUND, 6'd0, in_head == NIL);
                  end else if (in_head == NIL) begin
                    head[in_q] <= in_t;
                    tail[in_q] <= in_t;
                    done       <= 1'b1;
                    result     <= mk_rsp(ST_OK, 6'd0, 1'b0);
                  end else begin
                    state <= APPEND2;
                  end
                end
                OP_POP: begin
                  if (in_head == NIL) begin
                    done   <= 1'b1;
                    result <= mk_rsp(ST_EMPTY, 6'd0, 1'b1);
                  end else begin
                    state <= POP;
                  end
                end
                default: begin
                  // remove
                  if (in_head == NIL || !t_ok) begin
                    done   <= 1'b1;
                    result <= mk_rsp(ST_NOTFOUND, 6'd0, in_head == NIL);
                  end else if (in_head == in_t) begin
                    state <= RM_HEAD;
                  end else begin
                    prev  <= in_head;
                    steps <= '0;
                    state <= WALK;
                  end
                end
              endcase
            end
          end
        end
        APPEND2: begin
          tail[qi] <= tsk;
          done     <= 1'b1;
          result   <= mk_rsp(ST_OK, 6'd0, 1'b0);
          state    <= IDLE;
        end
        POP: begin
          // rdata holds the old head's successor
          head[qi] <= rdata;
          if (rdata == NIL) begin
            tail[qi] <= NIL;
          end
          done   <= 1'b1;
          result <= mk_rsp(ST_OK, 6'(cur_head), rdata == NIL);
          state  <= IDLE;
        end
        RM_HEAD: begin
          head[qi] <= rdata;
          if (cur_tail == tsk) begin
            tail[qi] <= NIL;
          end
          done   <= 1'b1;
          result <= mk_rsp(ST_OK, 6'd0, rdata == NIL);
          state  <= IDLE;
        end
        WALK: begin
          if (rdata == NIL) begin
            done   <= 1'b1;
            result <= mk_rsp(ST_NOTFOUND, 6'd0, 1'b0);
            state  <= IDLE;
          end else if (rdata == tsk) begin
            state <= RM_FIX;
          end else if (steps == SW'(NUM_TASKS - 1)) begin
            // step limit reached: queue is corrupt
            done   <= 1'b1;
            result <= mk_rsp(ST_NOTFOUND, 6'd0, 1'b0);
            state  <= IDLE;
          end else begin
            prev  <= rdata;
            steps <= steps + SW'(1);
          end
        end
        RM_FIX: begin
          // predecessor now skips the target
          if (cur_tail == tsk) begin
            tail[qi] <= prev;
          end
          state <= RM_CLR;
        end
        RM_CLR: begin
          done   <= 1'b1;
          result <= mk_rsp(ST_OK, 6'd0, 1'b0);
          state  <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/ltqm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
